// File: rtl/core/mrc_pkg.sv
package mrc_pkg;

  // Directions as carried on in_dir and out_dir
  typedef enum logic [2:0] {
    DIR_LOCAL = 3'd0,
    DIR_NORTH = 3'd1,
    DIR_EAST  = 3'd2,
    DIR_SOUTH = 3'd3,
    DIR_WEST  = 3'd4
  } dir_t;

  typedef enum logic [1:0] {
    MODE_XY     = 2'd0,
    MODE_TURN   = 2'd1,
    MODE_RANDOM = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    CFG_MODE    = 3'd0,
    CFG_COLUMNS = 3'd1,
    CFG_OWN_ID  = 3'd2,
    CFG_PORTMAP = 3'd3,
    CFG_VPV     = 3'd4,
    CFG_ESCAPE  = 3'd5
  } cfg_idx_t;

  localparam int DIR_WIDTH    = 3;
  localparam int DIR_COUNT    = 5;
  localparam int MODE_WIDTH   = 2;
  localparam int DIV_WIDTH    = 5;   // mesh_columns and vcs_per_vnet
  localparam int ESC_WIDTH    = 4;
  localparam int VC_WIDTH     = 8;
  localparam int REM_WIDTH    = DIV_WIDTH;
  localparam int CFG_IDX_WIDTH = 3;
  localparam int DIV_STEPS    = 4;   // restoring-division steps per stage

  localparam logic [DIV_WIDTH-1:0] COLUMNS_RESET = 5'd4;
  localparam logic [DIV_WIDTH-1:0] VPV_RESET     = 5'd4;

  // One restoring-division step: returns {quotient bit, new remainder}
  function automatic logic [REM_WIDTH:0] div_step(
    input logic [REM_WIDTH-1:0] rem,
    input logic                 num_bit,
    input logic [DIV_WIDTH-1:0] divisor
  );
    logic [REM_WIDTH:0] trial;
    logic [REM_WIDTH:0] diff;
    trial = {rem, num_bit};
    diff  = trial - {1'b0, divisor};
    if (trial >= {1'b0, divisor}) begin
      div_step = {1'b1, diff[REM_WIDTH-1:0]};
    end else begin
      div_step = {1'b0, trial[REM_WIDTH-1:0]};
    end
  endfunction

endpackage

// File: rtl/core/mesh_route_compute_unit.sv
// Pipeline: stage 0 captures start, the division stages follow, and done is registered from the last stage.
// Throughput: one packet per cycle; the id and VC divisions run 4 restoring steps
// per stage, so ID_WIDTH and the VC width set the pipeline depth.
// Reset (rst, synchronous) clears all stage valid bits and loads the register
// defaults; busy is high only during reset.
// The receiver cannot stall: done pulses for one cycle with out_port and out_dir.
module mesh_route_compute_unit #(
  parameter int ID_WIDTH   = 8,
  parameter int PORT_WIDTH = 3
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      start,
  output logic                                      busy,
  input  logic [ID_WIDTH-1:0]                       dest_id,
  input  logic [mrc_pkg::DIR_WIDTH-1:0]             in_dir,
  input  logic [mrc_pkg::VC_WIDTH-1:0]              in_vc,
  input  logic                                      random_bit,
  output logic                                      done,
  output logic [PORT_WIDTH-1:0]                     out_port,
  output logic [mrc_pkg::DIR_WIDTH-1:0]             out_dir,
  input  logic                                      cfg_we,
  input  logic [mrc_pkg::CFG_IDX_WIDTH-1:0]         cfg_index,
  input  logic [((mrc_pkg::DIR_COUNT*PORT_WIDTH > ID_WIDTH) ?
                 mrc_pkg::DIR_COUNT*PORT_WIDTH : ID_WIDTH)-1:0] cfg_data
);
  import mrc_pkg::*;

  localparam int MAP_WIDTH  = DIR_COUNT * PORT_WIDTH;
  localparam int NUM_MAX    = (ID_WIDTH > VC_WIDTH) ? ID_WIDTH : VC_WIDTH;
  localparam int DIV_STAGES = (NUM_MAX + DIV_STEPS - 1) / DIV_STEPS;
  localparam int TOTAL      = DIV_STAGES * DIV_STEPS;

  // Configuration registers
  logic [MODE_WIDTH-1:0] routing_mode;
  logic [DIV_WIDTH-1:0]  mesh_columns;
  logic [ID_WIDTH-1:0]   own_router_id;
  logic [MAP_WIDTH-1:0]  dir_port_map;
  logic [DIV_WIDTH-1:0]  vcs_per_vnet;
  logic [ESC_WIDTH-1:0]  escape_vc;

  always_ff @(posedge clk) begin
    if (rst) begin
      routing_mode  <= MODE_XY;
      mesh_columns  <= COLUMNS_RESET;
      own_router_id <= '0;
      dir_port_map  <= '0;
      vcs_per_vnet  <= VPV_RESET;
      escape_vc     <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_MODE:    routing_mode  <= cfg_data[MODE_WIDTH-1:0];
        CFG_COLUMNS: mesh_columns  <= cfg_data[DIV_WIDTH-1:0];
        CFG_OWN_ID:  own_router_id <= cfg_data[ID_WIDTH-1:0];
        CFG_PORTMAP: dir_port_map  <= cfg_data[MAP_WIDTH-1:0];
        CFG_VPV:     vcs_per_vnet  <= cfg_data[DIV_WIDTH-1:0];
        CFG_ESCAPE:  escape_vc     <= cfg_data[ESC_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  logic [DIV_WIDTH-1:0] cols;
  logic [DIV_WIDTH-1:0] vpv;
  logic [TOTAL-1:0]     own_num;

  assign cols    = (mesh_columns == '0) ? DIV_WIDTH'(1) : mesh_columns;
  assign vpv     = (vcs_per_vnet == '0) ? DIV_WIDTH'(1) : vcs_per_vnet;
  assign own_num = TOTAL'(own_router_id);

  assign busy = rst;

  // Pipeline: stage 0 captures the packet, each later stage adds DIV_STEPS division steps
  logic [DIV_STAGES:0]  valid;
  logic [TOTAL-1:0]     dest_num  [DIV_STAGES+1];
  logic [TOTAL-1:0]     vc_num    [DIV_STAGES+1];
  logic [REM_WIDTH-1:0] dest_rem  [DIV_STAGES+1];
  logic [ID_WIDTH-1:0]  dest_quot [DIV_STAGES+1];
  logic [REM_WIDTH-1:0] own_rem   [DIV_STAGES+1];
  logic [ID_WIDTH-1:0]  own_quot  [DIV_STAGES+1];
  logic [REM_WIDTH-1:0] vc_rem    [DIV_STAGES+1];
  logic [DIR_WIDTH-1:0] dir_in    [DIV_STAGES+1];
  logic                 rnd       [DIV_STAGES+1];

  logic [REM_WIDTH-1:0] dr_c [DIV_STAGES];
  logic [ID_WIDTH-1:0]  dq_c [DIV_STAGES];
  logic [REM_WIDTH-1:0] or_c [DIV_STAGES];
  logic [ID_WIDTH-1:0]  oq_c [DIV_STAGES];
  logic [REM_WIDTH-1:0] vr_c [DIV_STAGES];

  always_comb begin : step_blk
    logic [REM_WIDTH:0]   ds, os, vs;
    logic [REM_WIDTH-1:0] d_rem, o_rem, v_rem;
    logic [ID_WIDTH-1:0]  d_quot, o_quot;
    for (int k = 0; k < DIV_STAGES; k++) begin
      d_rem  = dest_rem[k];
      d_quot = dest_quot[k];
      o_rem  = own_rem[k];
      o_quot = own_quot[k];
      v_rem  = vc_rem[k];
      for (int j = 0; j < DIV_STEPS; j++) begin
        ds     = div_step(d_rem, dest_num[k][TOTAL-1-(k*DIV_STEPS+j)], cols);
        os     = div_step(o_rem, own_num[TOTAL-1-(k*DIV_STEPS+j)], cols);
        vs     = div_step(v_rem, vc_num[k][TOTAL-1-(k*DIV_STEPS+j)], vpv);
        d_rem  = ds[REM_WIDTH-1:0];
        d_quot = {d_quot[ID_WIDTH-2:0], ds[REM_WIDTH]};
        o_rem  = os[REM_WIDTH-1:0];
        o_quot = {o_quot[ID_WIDTH-2:0], os[REM_WIDTH]};
        v_rem  = vs[REM_WIDTH-1:0];
      end
      dr_c[k] = d_rem;
      dq_c[k] = d_quot;
      or_c[k] = o_rem;
      oq_c[k] = o_quot;
      vr_c[k] = v_rem;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= {valid[DIV_STAGES-1:0], start && !busy};
    end
    dest_num[0]  <= TOTAL'(dest_id);
    vc_num[0]    <= TOTAL'(in_vc);
    dest_rem[0]  <= '0;
    dest_quot[0] <= '0;
    own_rem[0]   <= '0;
    own_quot[0]  <= '0;
    vc_rem[0]    <= '0;
    dir_in[0]    <= in_dir;
    rnd[0]       <= random_bit;
    for (int k = 0; k < DIV_STAGES; k++) begin
      dest_num[k+1]  <= dest_num[k];
      vc_num[k+1]    <= vc_num[k];
      dest_rem[k+1]  <= dr_c[k];
      dest_quot[k+1] <= dq_c[k];
      own_rem[k+1]   <= or_c[k];
      own_quot[k+1]  <= oq_c[k];
      vc_rem[k+1]    <= vr_c[k];
      dir_in[k+1]    <= dir_in[k];
      rnd[k+1]       <= rnd[k];
    end
  end

  // Route decision on the finished coordinates
  logic                 x_same, y_same, is_local;
  dir_t                 xd, yd, straight, dir_sel;
  mode_t                mode_eff;
  logic [PORT_WIDTH-1:0] port_sel;

  always_comb begin
    x_same   = dest_rem[DIV_STAGES] == own_rem[DIV_STAGES];
    y_same   = dest_quot[DIV_STAGES] == own_quot[DIV_STAGES];
    is_local = dest_num[DIV_STAGES][ID_WIDTH-1:0] == own_router_id;
    xd       = (dest_rem[DIV_STAGES] >= own_rem[DIV_STAGES]) ? DIR_EAST : DIR_WEST;
    yd       = (dest_quot[DIV_STAGES] >= own_quot[DIV_STAGES]) ? DIR_NORTH : DIR_SOUTH;
    straight = (dir_in[DIV_STAGES] == DIR_EAST) ? DIR_WEST : DIR_EAST;
    mode_eff = mode_t'(routing_mode);
    // in random mode only, the escape VC falls back to XY
    if (mode_eff == MODE_RANDOM && vc_rem[DIV_STAGES] == {1'b0, escape_vc}) begin
      mode_eff = MODE_XY;
    end

    if (is_local) begin
      dir_sel = DIR_LOCAL;
    end else begin
      case (mode_eff)
        MODE_TURN: begin
          if (x_same) begin
            dir_sel = yd;
          end else if (y_same) begin
            dir_sel = xd;
          end else if (dir_in[DIV_STAGES] == DIR_EAST || dir_in[DIV_STAGES] == DIR_WEST) begin
            if (yd == DIR_NORTH) begin
              dir_sel = straight;
            end else begin
              dir_sel = rnd[DIV_STAGES] ? straight : DIR_SOUTH;
            end
          end else if (yd == DIR_SOUTH) begin
            dir_sel = rnd[DIV_STAGES] ? xd : DIR_SOUTH;
          end else begin
            dir_sel = DIR_NORTH;
          end
        end
        MODE_RANDOM: begin
          if (x_same) begin
            dir_sel = yd;
          end else if (y_same) begin
            dir_sel = xd;
          end else begin
            dir_sel = rnd[DIV_STAGES] ? xd : yd;
          end
        end
        default: begin
          dir_sel = x_same ? yd : xd;
        end
      endcase
    end

    case (dir_sel)
      DIR_LOCAL: port_sel = dir_port_map[0*PORT_WIDTH +: PORT_WIDTH];
      DIR_NORTH: port_sel = dir_port_map[1*PORT_WIDTH +: PORT_WIDTH];
      DIR_EAST:  port_sel = dir_port_map[2*PORT_WIDTH +: PORT_WIDTH];
      DIR_SOUTH: port_sel = dir_port_map[3*PORT_WIDTH +: PORT_WIDTH];
      DIR_WEST:  port_sel = dir_port_map[4*PORT_WIDTH +: PORT_WIDTH];
      default:   port_sel = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= valid[DIV_STAGES];
    end
    out_port <= port_sel;
    out_dir  <= dir_sel;
  end

  a_done_follows_pipe: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (done == $past(valid[DIV_STAGES])))
    else $error("done does not follow the last pipeline stage");

  a_local_iff_own: assert property (@(posedge clk) disable iff (rst)
    done |-> ((out_dir == DIR_LOCAL) ==
              ($past(dest_num[DIV_STAGES][ID_WIDTH-1:0]) == own_router_id)))
    else $error("local direction chosen for a foreign destination or missed");

  a_dir_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (out_dir <= DIR_WEST))
    else $error("out_dir outside the five directions");

  a_port_matches_map: assert property (@(posedge clk) disable iff (rst)
    done |-> (out_port == dir_port_map[out_dir*PORT_WIDTH +: PORT_WIDTH]))
    else $error("out_port disagrees with the direction map");

  a_rem_below_cols: assert property (@(posedge clk) disable iff (rst)
    valid[DIV_STAGES] |-> (dest_rem[DIV_STAGES] < cols && vc_rem[DIV_STAGES] < vpv))
    else $error("division remainder not below its divisor");

endmodule
